// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/slmtf_pkg.sv -----
// ----------------------------------------------------------------------------
// slmtf_pkg
// shared types and codes of the sorted list with move-to-front
// ----------------------------------------------------------------------------
`default_nettype none

package slmtf_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_MTF    = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_MOVED     = 3'd1,
        ST_AT_FRONT  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic signed [VALUE_W-1:0] t_value;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } t_dp_ctl;

endpackage

`default_nettype wire

// ----- sv/sorted_list_with_move_to_front_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_list_with_move_to_front_unit
// ordered list of signed 32-bit values with insert and move-to-front
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                | tuser
//  s_      | in  | [31:0] value                         | [0] command
//  m_      | out | [4:0] position, [9:5] entry_count    | [2:0] status
//
//  an item passes a compare step, which checks every cell against the
//  value in parallel, and an update step, which locates the first hit
//  and shifts the neighbor cells; a new transaction is taken in the
//  update cycle of the previous item while the result register drains
//  a stalled result holds the update cycle and with it the input side
//  synchronous active-low reset empties the list; no clearing pass needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_list_with_move_to_front_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    input  wire logic        i_s_tuser,   // [0] command
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [4:0] position, [9:5] entry_count
    output logic [2:0]       o_m_tuser    // [2:0] status
);

    slmtf_pkg::t_dp_ctl ctl;
    slmtf_pkg::t_status status;
    slmtf_pkg::t_pos    position;
    slmtf_pkg::t_pos    entry_count;

    // sequencer: owns the handshakes and the result-valid flag
    slmtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctl      (ctl)
    );

    // list cells, compare flags, count and result payload
    slmtf_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_cmd         (slmtf_pkg::t_cmd'(i_s_tuser)),
        .i_value       (slmtf_pkg::t_value'(i_s_tdata)),
        .o_status      (status),
        .o_position    (position),
        .o_entry_count (entry_count)
    );

    assign o_m_tdata = {6'd0, entry_count, position};
    assign o_m_tuser = status;

    // the compare cycle always follows an accepted transaction
    `ASSERT_NEXT(a_cmp_blocks_input, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input accepted during compare cycle")
    // dropped inserts report position zero
    `ASSERT_IMPL(a_full_pos_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == slmtf_pkg::ST_FULL), o_m_tdata[4:0] == 5'd0, "full status with nonzero position")
    // a dropped insert only happens at capacity
    `ASSERT_IMPL(a_full_count, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == slmtf_pkg::ST_FULL), o_m_tdata[9:5] == 5'(CAPACITY), "full status below capacity")

endmodule

`default_nettype wire

// ----- sv/slmtf_ctrl.sv -----
// ----------------------------------------------------------------------------
// slmtf_ctrl
// sequencer: capture, compare, update, with a one-deep result register
// ----------------------------------------------------------------------------
`default_nettype none

module slmtf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output slmtf_pkg::t_dp_ctl      o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   upd_go;
    logic   accept;

    // update may retire only when the result slot is free or being drained
    assign upd_go     = (r_state == S_UPD) && (!r_out_valid || i_m_tready);
    assign o_s_tready = (r_state == S_IDLE) || upd_go;
    assign accept     = o_s_tready && i_s_tvalid;
    assign o_m_tvalid = r_out_valid;

    assign o_ctl.load    = accept;
    assign o_ctl.compare = (r_state == S_CMP);
    assign o_ctl.update  = upd_go;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (upd_go) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- sv/slmtf_dp.sv -----
// ----------------------------------------------------------------------------
// slmtf_dp
// row of list cells with per-cell compare, neighbor shift and result register
// ----------------------------------------------------------------------------
`default_nettype none

module slmtf_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slmtf_pkg::t_dp_ctl   i_ctl,
    input  wire slmtf_pkg::t_cmd      i_cmd,
    input  wire slmtf_pkg::t_value    i_value,
    output slmtf_pkg::t_status        o_status,
    output slmtf_pkg::t_pos           o_position,
    output slmtf_pkg::t_pos           o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    slmtf_pkg::t_value  r_cell [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    slmtf_pkg::t_cmd    r_cmd;
    slmtf_pkg::t_value  r_value;
    logic [CAPACITY-1:0] r_ge;
    logic [CAPACITY-1:0] r_eq;

    slmtf_pkg::t_status r_status;
    slmtf_pkg::t_pos    r_position;
    slmtf_pkg::t_pos    r_entry_count;

    logic [CNT_W-1:0]   ge_pos;
    logic [CNT_W-1:0]   eq_pos;
    logic [CNT_W-1:0]   sel_pos;
    logic               full;
    logic               do_ins;
    logic               do_mv;
    slmtf_pkg::t_status n_status;
    logic [CNT_W-1:0]   n_position;

    // first held entry >= value (count when none)
    always_comb begin
        ge_pos = r_count;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_ge[IDX_W'(i)]) begin
                ge_pos = CNT_W'(i);
            end
        end
    end

    // first held entry == value past the front (count when none)
    always_comb begin
        eq_pos = r_count;
        for (int i = CAPACITY - 1; i >= 1; i--) begin
            if (r_eq[IDX_W'(i)]) begin
                eq_pos = CNT_W'(i);
            end
        end
    end

    assign full    = (r_count == CNT_W'(CAPACITY));
    assign do_ins  = (r_cmd == slmtf_pkg::CMD_INSERT) && !full;
    assign do_mv   = (r_cmd == slmtf_pkg::CMD_MTF) && (r_count != '0) && !r_eq[0]
                     && (eq_pos < r_count);
    assign sel_pos = do_ins ? ge_pos : eq_pos;

    always_comb begin
        n_count    = r_count;
        n_position = '0;
        if (r_cmd == slmtf_pkg::CMD_INSERT) begin
            if (full) begin
                n_status = slmtf_pkg::ST_FULL;
            end else begin
                n_status   = slmtf_pkg::ST_INSERTED;
                n_position = ge_pos;
                n_count    = r_count + CNT_W'(1);
            end
        end else if (r_count == '0) begin
            n_status = slmtf_pkg::ST_EMPTY;
        end else if (r_eq[0]) begin
            n_status = slmtf_pkg::ST_AT_FRONT;
        end else if (do_mv) begin
            n_status   = slmtf_pkg::ST_MOVED;
            n_position = eq_pos;
        end else begin
            n_status = slmtf_pkg::ST_NOT_FOUND;
        end
    end

    // per-cell storage, compare and neighbor shift
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic held;
        assign held = (CNT_W'(g) < r_count);

        always_ff @(posedge i_clk) begin
            if (i_ctl.compare) begin
                r_ge[g] <= held && (r_cell[g] >= r_value);
                r_eq[g] <= held && (r_cell[g] == r_value);
            end
        end

        if (g == 0) begin : g_front
            always_ff @(posedge i_clk) begin
                if (i_ctl.update) begin
                    if ((do_ins && sel_pos == '0) || do_mv) begin
                        r_cell[g] <= r_value;
                    end
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_ctl.update) begin
                    if (do_ins) begin
                        if (CNT_W'(g) == sel_pos) begin
                            r_cell[g] <= r_value;
                        end else if (CNT_W'(g) > sel_pos && CNT_W'(g) <= r_count) begin
                            r_cell[g] <= r_cell[g-1];
                        end
                    end else if (do_mv && CNT_W'(g) <= sel_pos) begin
                        r_cell[g] <= r_cell[g-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.update) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (i_ctl.update) begin
            r_status      <= n_status;
            r_position    <= slmtf_pkg::t_pos'(n_position);
            r_entry_count <= slmtf_pkg::t_pos'(n_count);
        end
    end

    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted list with move-to-front unit: a local
// copy of the list predicts status, position and entry count for every
// accepted command, and each result transaction is compared in order
// ----------------------------------------------------------------------------

module tb_top;

    localparam int          CAPACITY       = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int unsigned TAIL_CYCLES    = 12;    // settle time after the last result
    localparam int unsigned RANDOM_ITEMS   = 1375;
    localparam int unsigned CALM_ITEMS     = 300;   // closing stretch with no idling
    localparam slmtf_pkg::t_value VAL_MIN  = 32'sh8000_0000;
    localparam slmtf_pkg::t_value VAL_MAX  = 32'sh7fff_ffff;

    typedef logic [$clog2(CAPACITY)-1:0] t_idx;

    // one result transaction as the list should report it
    typedef struct {
        slmtf_pkg::t_status status;
        slmtf_pkg::t_pos    position;
        slmtf_pkg::t_pos    entry_count;
    } t_list_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [31:0] s_tdata    = '0;    // [31:0] value
    logic        s_tuser    = 1'b0;  // [0] command
    logic        m_tready   = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;          // [4:0] position, [9:5] entry_count
    logic [2:0]  o_m_tuser;          // [2:0] status

    // predicted list contents and the results still owed by the unit
    slmtf_pkg::t_value held_values [CAPACITY];
    int unsigned       held_count = 0;
    t_list_result      pending_results[$];

    int unsigned mismatches = 0;
    bit          idle_en    = 1'b0;

    sorted_list_with_move_to_front_unit #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // list predictor: applies one command to the local copy and queues the
    // result it must produce
    // ------------------------------------------------------------------------
    function automatic void predict_list_op(input slmtf_pkg::t_cmd cmd,
                                            input slmtf_pkg::t_value value);
        t_list_result res;
        int           hit;
        hit          = -1;
        res.position = '0;
        if (cmd == slmtf_pkg::CMD_INSERT) begin
            if (held_count >= CAPACITY) begin
                // no room: list untouched, insert dropped
                res.status = slmtf_pkg::ST_FULL;
            end else begin
                // goes ahead of the first entry that is not smaller
                hit = int'(held_count);
                for (int i = 0; i < int'(held_count); i++) begin
                    if (held_values[t_idx'(i)] >= value) begin
                        hit = i;
                        break;
                    end
                end
                for (int i = int'(held_count); i > hit; i--) begin
                    held_values[t_idx'(i)] = held_values[t_idx'(i-1)];
                end
                held_values[t_idx'(hit)] = value;
                held_count++;
                res.status   = slmtf_pkg::ST_INSERTED;
                res.position = slmtf_pkg::t_pos'(hit);
            end
        end else if (held_count == 0) begin
            res.status = slmtf_pkg::ST_EMPTY;
        end else if (held_values[0] == value) begin
            res.status = slmtf_pkg::ST_AT_FRONT;
        end else begin
            // first equal entry past the head
            for (int i = 1; i < int'(held_count); i++) begin
                if (held_values[t_idx'(i)] == value) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                res.status = slmtf_pkg::ST_NOT_FOUND;
            end else begin
                for (int i = hit; i > 0; i--) begin
                    held_values[t_idx'(i)] = held_values[t_idx'(i-1)];
                end
                held_values[0] = value;
                res.status     = slmtf_pkg::ST_MOVED;
                res.position   = slmtf_pkg::t_pos'(hit);
            end
        end
        res.entry_count = slmtf_pkg::t_pos'(held_count);
        pending_results.push_back(res);
    endfunction

    // a held value picked at random
    function automatic slmtf_pkg::t_value pick_held();
        return held_values[t_idx'($urandom_range(0, held_count - 1))];
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional random gap, then hold the command until accepted;
    // tvalid stays high afterwards so back-to-back commands never toggle it
    // ------------------------------------------------------------------------
    task automatic send_command(input slmtf_pkg::t_cmd cmd, input slmtf_pkg::t_value value);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predict_list_op(cmd, value);
    endtask

    // drop tvalid and hold off until every owed result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: tready low in random bursts while idling is enabled
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every result transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d position %0d entry_count %0d",
                       o_m_tuser, o_m_tdata[4:0], o_m_tdata[9:5]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_m_tuser);
                    mismatches++;
                end
                if (o_m_tdata[4:0] !== want.position) begin
                    $error("position: expected %0d, actual %0d",
                           want.position, o_m_tdata[4:0]);
                    mismatches++;
                end
                if (o_m_tdata[9:5] !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, o_m_tdata[9:5]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: ends the run when the interface goes quiet for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        do begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // move-to-front on a list that holds nothing yet
    task automatic test_empty_move();
        send_command(slmtf_pkg::CMD_MTF, 32'sd5);
    endtask

    // ordered inserts with both extremes, a duplicate and a repeated maximum
    task automatic test_insert_order();
        send_command(slmtf_pkg::CMD_INSERT, 32'sd0);
        send_command(slmtf_pkg::CMD_INSERT, VAL_MAX);
        send_command(slmtf_pkg::CMD_INSERT, VAL_MIN);
        send_command(slmtf_pkg::CMD_INSERT, -32'sd1);
        send_command(slmtf_pkg::CMD_INSERT, 32'sd0);     // lands ahead of the equal entry
        send_command(slmtf_pkg::CMD_INSERT, VAL_MAX);
    endtask

    // head already matching, first of two duplicates, move from the tail side,
    // and values that are not held
    task automatic test_move_cases();
        send_command(slmtf_pkg::CMD_MTF, VAL_MIN);
        send_command(slmtf_pkg::CMD_MTF, 32'sd0);
        send_command(slmtf_pkg::CMD_MTF, 32'sd0);
        send_command(slmtf_pkg::CMD_MTF, VAL_MAX);
        send_command(slmtf_pkg::CMD_MTF, 32'sd7);
        send_command(slmtf_pkg::CMD_MTF, 32'sh5555_5555);
    endtask

    // fill up to capacity, then an insert that must be dropped and a move of
    // the value held in the last slot
    task automatic test_fill_to_full();
        send_command(slmtf_pkg::CMD_INSERT, 32'shaaaa_aaaa);
        send_command(slmtf_pkg::CMD_INSERT, 32'sh5555_5555);
        while (held_count < CAPACITY) begin
            send_command(slmtf_pkg::CMD_INSERT, slmtf_pkg::t_value'($urandom));
        end
        send_command(slmtf_pkg::CMD_INSERT, 32'sd1);
        send_command(slmtf_pkg::CMD_MTF, held_values[t_idx'(held_count - 1)]);
    endtask

    // mostly moves of held values with random picks, plus dropped inserts,
    // near misses and arbitrary values; the last stretch runs without idling
    task automatic test_random_traffic(input int unsigned n_items);
        slmtf_pkg::t_value value;
        int unsigned       roll;
        for (int unsigned k = 0; k < n_items; k++) begin
            idle_en = (k + CALM_ITEMS < n_items);
            roll    = $urandom_range(0, 99);
            if (roll < 25) begin
                case ($urandom_range(0, 9))
                    0:       value = VAL_MIN;
                    1:       value = VAL_MAX;
                    default: value = slmtf_pkg::t_value'($urandom);
                endcase
                send_command(slmtf_pkg::CMD_INSERT, value);
            end else if (roll < 80 && held_count != 0) begin
                send_command(slmtf_pkg::CMD_MTF, pick_held());
            end else if (roll < 90 && held_count != 0) begin
                value = pick_held();
                value = ($urandom_range(0, 1) != 0) ? value + 32'sd1 : value - 32'sd1;
                send_command(slmtf_pkg::CMD_MTF, value);
            end else begin
                send_command(slmtf_pkg::CMD_MTF, slmtf_pkg::t_value'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        test_empty_move();
        wait_for_results();
        test_insert_order();
        wait_for_results();
        test_move_cases();
        wait_for_results();
        test_fill_to_full();
        wait_for_results();
        test_random_traffic(RANDOM_ITEMS);
        wait_for_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sorted_list_with_move_to_front_unit.f -----
+incdir+sv
sv/slmtf_pkg.sv
sv/slmtf_ctrl.sv
sv/slmtf_dp.sv
sv/sorted_list_with_move_to_front_unit.sv
tb/sv/tb_top.sv
